[sv/jfp_pkg.sv]
package jfp_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ACTION_W   = 3;
   localparam int KIND_W     = 3;
   localparam int FILL_OUT_W = 10;
   localparam int LEN_REG_W  = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int MIN_LEN    = 2;
   localparam int RESET_LEN  = 1024;

   // word index of each csr register (byte address 4*index)
   typedef enum logic {
      REG_FIFO_LENGTH = 1'b0
   } reg_idx_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE   = 3'd0,
      ACT_PULL    = 3'd1,
      ACT_FLUSH   = 3'd2,
      ACT_CLEAR   = 3'd3,
      ACT_DRAINED = 3'd4
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE     = 3'd0,
      KIND_DATA     = 3'd1,
      KIND_SILENCE  = 3'd2,
      KIND_UNDERRUN = 3'd3,
      KIND_FLUSH    = 3'd4,
      KIND_FLUSHED  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EXEC   = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic finish;
   } cmd_type;

endpackage

[sv/jfp_if.sv]
interface jfp_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [jfp_pkg::ACTION_W-1:0]          action;
   logic signed [jfp_pkg::SAMPLE_W-1:0]   sample;
   logic                                  burst_end;

   modport source (output valid, action, sample, burst_end, input ready);
   modport sink (input valid, action, sample, burst_end, output ready);
endinterface

interface jfp_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [jfp_pkg::KIND_W-1:0]            kind;
   logic signed [jfp_pkg::SAMPLE_W-1:0]   out_sample;
   logic [jfp_pkg::FILL_OUT_W-1:0]        fill_level;
   logic                                  overflow;

   modport source (output valid, kind, out_sample, fill_level, overflow, input ready);
   modport sink (input valid, kind, out_sample, fill_level, overflow, output ready);
endinterface

[sv/jfp_ctrl.sv]
module jfp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output jfp_pkg::cmd_type cmd
);

   jfp_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jfp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register is free when empty or its beat leaves this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         jfp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = jfp_pkg::ST_EXEC;
            end
         end
         jfp_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = jfp_pkg::ST_FINISH;
         end
         jfp_pkg::ST_FINISH: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = jfp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jfp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/jfp_dp.sv]
module jfp_dp #(
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  jfp_pkg::cmd_type                      cmd,
   input  logic [jfp_pkg::ACTION_W-1:0]          req_action,
   input  logic signed [jfp_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                  req_burst_end,
   output logic [jfp_pkg::KIND_W-1:0]            rsp_kind,
   output logic signed [jfp_pkg::SAMPLE_W-1:0]   rsp_out_sample,
   output logic [jfp_pkg::FILL_OUT_W-1:0]        rsp_fill_level,
   output logic                                  rsp_overflow,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [jfp_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [jfp_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [jfp_pkg::CSR_DATA_W-1:0]        csr_prdata
);

   localparam int AW      = $clog2(DEPTH);
   localparam int LEN_W   = $clog2(DEPTH + 1);
   localparam int LEN_RST = (DEPTH < jfp_pkg::RESET_LEN) ? DEPTH : jfp_pkg::RESET_LEN;

   logic [jfp_pkg::SAMPLE_W-1:0] store [DEPTH];

   // item registers
   logic [jfp_pkg::ACTION_W-1:0] act_ff;
   logic [jfp_pkg::SAMPLE_W-1:0] smp_ff;
   logic                         burst_ff;

   // fifo state
   logic [jfp_pkg::LEN_REG_W-1:0] len_reg_ff;
   logic [LEN_W-1:0]              len_ff;
   logic [AW-1:0]                 wr_ptr_ff, rd_ptr_ff, fill_ff;
   logic                          pre_ff, flush_ff;
   logic [jfp_pkg::KIND_W-1:0]    kind_ff;
   logic                          ovf_ff;
   logic [jfp_pkg::SAMPLE_W-1:0]  rd_data_ff;

   // result register
   logic [jfp_pkg::KIND_W-1:0]    out_kind_ff;
   logic [jfp_pkg::SAMPLE_W-1:0]  out_sample_ff;
   logic [jfp_pkg::FILL_OUT_W-1:0] out_fill_ff;
   logic                          out_ovf_ff;

   logic                          cfg_wr;
   logic [LEN_W-1:0]              len_in;
   logic [LEN_W-1:0]              half;
   logic [LEN_W-1:0]              wr_inc, rd_inc, fill_inc;
   logic [AW-1:0]                 wr_wrap, rd_wrap;
   logic [LEN_W:0]                rd_half_sum;
   logic [AW-1:0]                 rd_half;
   logic                          full_hit, fill_zero, release_pre;
   logic [AW+jfp_pkg::FILL_OUT_W-1:0] fill_wide;

   assign half      = len_ff >> 1;
   assign fill_zero = (fill_ff == '0);

   assign wr_inc  = LEN_W'(wr_ptr_ff) + LEN_W'(1);
   assign wr_wrap = (wr_inc == len_ff) ? '0 : AW'(wr_inc);
   assign rd_inc  = LEN_W'(rd_ptr_ff) + LEN_W'(1);
   assign rd_wrap = (rd_inc == len_ff) ? '0 : AW'(rd_inc);

   // a write that would meet the read pointer drops the oldest half
   assign fill_inc    = LEN_W'(fill_ff) + LEN_W'(1);
   assign full_hit    = (fill_inc == len_ff);
   assign rd_half_sum = {1'b0, LEN_W'(rd_ptr_ff)} + {1'b0, half};
   assign rd_half     = (rd_half_sum >= {1'b0, len_ff}) ?
                        AW'(rd_half_sum - {1'b0, len_ff}) : AW'(rd_half_sum);

   assign release_pre = burst_ff && !fill_zero &&
                        (!pre_ff || (LEN_W'(fill_ff) >= half));

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == jfp_pkg::REG_FIFO_LENGTH);

   // out-of-range lengths clamp to the usable span
   always_comb begin
      if (32'(csr_pwdata[jfp_pkg::LEN_REG_W-1:0]) < 32'(jfp_pkg::MIN_LEN)) begin
         len_in = LEN_W'(jfp_pkg::MIN_LEN);
      end else if (32'(csr_pwdata[jfp_pkg::LEN_REG_W-1:0]) > 32'(DEPTH)) begin
         len_in = LEN_W'(DEPTH);
      end else begin
         len_in = LEN_W'(csr_pwdata[jfp_pkg::LEN_REG_W-1:0]);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == jfp_pkg::REG_FIFO_LENGTH) begin
         csr_prdata = jfp_pkg::CSR_DATA_W'(len_reg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         smp_ff   <= req_sample;
         burst_ff <= req_burst_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && (act_ff == jfp_pkg::ACT_WRITE)) begin
         store[wr_ptr_ff] <= smp_ff;
      end
      if (cmd.execute) begin
         rd_data_ff <= store[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_reg_ff <= jfp_pkg::LEN_REG_W'(jfp_pkg::RESET_LEN);
         len_ff     <= LEN_W'(LEN_RST);
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         pre_ff     <= 1'b1;
         flush_ff   <= 1'b0;
         kind_ff    <= jfp_pkg::KIND_NONE;
         ovf_ff     <= 1'b0;
      end else if (cfg_wr) begin
         len_reg_ff <= csr_pwdata[jfp_pkg::LEN_REG_W-1:0];
         len_ff     <= len_in;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         pre_ff     <= 1'b1;
         flush_ff   <= 1'b0;
      end else if (cmd.execute) begin
         kind_ff <= jfp_pkg::KIND_NONE;
         ovf_ff  <= 1'b0;
         case (act_ff)
            jfp_pkg::ACT_WRITE: begin
               if (flush_ff) begin
                  flush_ff <= 1'b0;
                  pre_ff   <= 1'b1;
               end
               wr_ptr_ff <= wr_wrap;
               if (full_hit) begin
                  rd_ptr_ff <= rd_half;
                  fill_ff   <= AW'(len_ff - half);
                  ovf_ff    <= 1'b1;
               end else begin
                  fill_ff <= AW'(fill_inc);
               end
            end
            jfp_pkg::ACT_PULL: begin
               if (fill_zero) begin
                  if (flush_ff) begin
                     kind_ff <= jfp_pkg::KIND_FLUSH;
                  end else begin
                     kind_ff <= jfp_pkg::KIND_UNDERRUN;
                     pre_ff  <= 1'b1;
                  end
               end else if (pre_ff && !flush_ff) begin
                  kind_ff <= jfp_pkg::KIND_SILENCE;
               end else begin
                  kind_ff   <= jfp_pkg::KIND_DATA;
                  rd_ptr_ff <= rd_wrap;
                  fill_ff   <= fill_ff - AW'(1);
                  if ((fill_ff == AW'(1)) && !flush_ff) begin
                     pre_ff <= 1'b1;
                  end
               end
            end
            jfp_pkg::ACT_FLUSH: begin
               flush_ff <= 1'b1;
               if (fill_zero) begin
                  kind_ff <= jfp_pkg::KIND_FLUSH;
               end
            end
            jfp_pkg::ACT_CLEAR: begin
               wr_ptr_ff <= '0;
               rd_ptr_ff <= '0;
               fill_ff   <= '0;
               pre_ff    <= 1'b1;
               if (flush_ff) begin
                  flush_ff <= 1'b0;
                  if (!fill_zero) begin
                     kind_ff <= jfp_pkg::KIND_FLUSH;
                  end
               end
            end
            jfp_pkg::ACT_DRAINED: begin
               if (fill_zero) begin
                  pre_ff <= 1'b1;
                  if (flush_ff) begin
                     flush_ff <= 1'b0;
                     kind_ff  <= jfp_pkg::KIND_FLUSHED;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.finish && (act_ff == jfp_pkg::ACT_WRITE)) begin
         // burst end releases prebuffering once the new fill is known
         if (release_pre) begin
            pre_ff <= 1'b0;
         end
         if (fill_zero) begin
            pre_ff <= 1'b1;
         end
      end
   end

   assign fill_wide = (AW + jfp_pkg::FILL_OUT_W)'(fill_ff);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_kind_ff   <= kind_ff;
         out_sample_ff <= (kind_ff == jfp_pkg::KIND_DATA) ? rd_data_ff : '0;
         out_fill_ff   <= fill_wide[jfp_pkg::FILL_OUT_W-1:0];
         out_ovf_ff    <= ovf_ff;
      end
   end

   assign rsp_kind       = out_kind_ff;
   assign rsp_out_sample = out_sample_ff;
   assign rsp_fill_level = out_fill_ff;
   assign rsp_overflow   = out_ovf_ff;

endmodule

[sv/jitter_fifo_prebuffer_top.sv]
// channel   dir   fields                                   beat when
// req       in    action, sample, burst_end                req.valid && req.ready
// rsp       out   kind, out_sample, fill_level, overflow   rsp.valid && rsp.ready
// csr       in    fifo_length at byte address 0            psel, penable, pwrite high
//
// each item passes through accept, execute (pointer update and one store
// access) and finish (prebuffer release and load of the result register)
// one result register; the next item is accepted while a result waits, and
// the finish cycle stretches while rsp is stalled with a result still held
// reset clears pointers and flags and restores the fifo length; stored samples are not cleared

module jitter_fifo_prebuffer_top #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   jfp_req_if.sink                             req,
   jfp_rsp_if.source                           rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [jfp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [jfp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [jfp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   jfp_pkg::cmd_type cmd;

   assign csr_pready = 1'b1;

   jfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   jfp_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_action     (req.action),
      .req_sample     (req.sample),
      .req_burst_end  (req.burst_end),
      .rsp_kind       (rsp.kind),
      .rsp_out_sample (rsp.out_sample),
      .rsp_fill_level (rsp.fill_level),
      .rsp_overflow   (rsp.overflow),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata)
   );

endmodule

[test/jitter_fifo_prebuffer_top_tb.sv]
module jitter_fifo_prebuffer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 1024;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned ITEMS_PER_PHASE = 117;
   localparam int NUM_PHASES = 9;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [jfp_pkg::ACTION_W-1:0]        action;
      logic signed [jfp_pkg::SAMPLE_W-1:0] sample;
      logic                                burst_end;
   } jitter_in_type;

   typedef struct packed {
      jfp_pkg::kind_type                   kind;
      logic signed [jfp_pkg::SAMPLE_W-1:0] out_sample;
      logic [jfp_pkg::FILL_OUT_W-1:0]      fill;
      logic                                overflow;
   } jitter_out_type;

   typedef struct packed {
      bit                            is_cfg;
      logic [jfp_pkg::LEN_REG_W-1:0] cfg_len;
      jitter_in_type                 item;
      bit                            typed;
      jitter_out_type                want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [jfp_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [jfp_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [jfp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   jfp_req_if req_ch();
   jfp_rsp_if rsp_ch();

   jitter_fifo_prebuffer_top #(
      .DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state
   logic [jfp_pkg::SAMPLE_W-1:0]  ring_mem [DEPTH];
   int unsigned                   head_ptr;
   int unsigned                   tail_ptr;
   bit                            priming;
   bit                            drain_pend;
   logic [jfp_pkg::LEN_REG_W-1:0] len_csr;

   jitter_out_type jitter_out_q [$];
   int unsigned mismatch_count;
   int unsigned cycle_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   dir_row_type dir_rows [23];
   logic [jfp_pkg::LEN_REG_W-1:0] phase_len [NUM_PHASES] = '{11'd0, 11'd3, 11'd2047, 11'd7,
                                                            11'd1, 11'd40, 11'd2, 11'd33,
                                                            11'd1024};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned used_len();
      if (len_csr < jfp_pkg::LEN_REG_W'(jfp_pkg::MIN_LEN)) return jfp_pkg::MIN_LEN;
      if (len_csr > jfp_pkg::LEN_REG_W'(DEPTH)) return DEPTH;
      return int'(len_csr);
   endfunction

   function automatic int unsigned held_count(input int unsigned len);
      return (head_ptr + len - tail_ptr) % len;
   endfunction

   function automatic jitter_out_type jitter_fifo_step(input jitter_in_type it);
      jitter_out_type r;
      int unsigned len;
      int unsigned fill;
      len = used_len();
      head_ptr = head_ptr % len;
      tail_ptr = tail_ptr % len;
      fill = held_count(len);
      r = '{jfp_pkg::KIND_NONE, '0, '0, 1'b0};
      case (it.action)
         jfp_pkg::ACT_WRITE: begin
            if (drain_pend) begin
               drain_pend = 1'b0;
               priming = 1'b1;
            end
            ring_mem[head_ptr] = it.sample;
            head_ptr = (head_ptr + 1) % len;
            // head caught the tail: drop the oldest half
            if (head_ptr == tail_ptr) begin
               tail_ptr = (tail_ptr + len / 2) % len;
               r.overflow = 1'b1;
            end
            fill = held_count(len);
            if (it.burst_end && fill > 0 && (!priming || fill >= len / 2)) priming = 1'b0;
            if (fill == 0) priming = 1'b1;
         end
         jfp_pkg::ACT_PULL: begin
            if (fill == 0) begin
               if (drain_pend) begin
                  r.kind = jfp_pkg::KIND_FLUSH;
               end else begin
                  r.kind = jfp_pkg::KIND_UNDERRUN;
                  priming = 1'b1;
               end
            end else if (priming && !drain_pend) begin
               r.kind = jfp_pkg::KIND_SILENCE;
            end else begin
               r.kind = jfp_pkg::KIND_DATA;
               r.out_sample = ring_mem[tail_ptr];
               tail_ptr = (tail_ptr + 1) % len;
               if (held_count(len) == 0 && !drain_pend) priming = 1'b1;
            end
         end
         jfp_pkg::ACT_FLUSH: begin
            drain_pend = 1'b1;
            if (fill == 0) r.kind = jfp_pkg::KIND_FLUSH;
         end
         jfp_pkg::ACT_CLEAR: begin
            head_ptr = 0;
            tail_ptr = 0;
            priming = 1'b1;
            if (drain_pend) begin
               drain_pend = 1'b0;
               if (fill != 0) r.kind = jfp_pkg::KIND_FLUSH;
            end
         end
         jfp_pkg::ACT_DRAINED: begin
            if (fill == 0) begin
               if (drain_pend) begin
                  drain_pend = 1'b0;
                  r.kind = jfp_pkg::KIND_FLUSHED;
               end
               priming = 1'b1;
            end
         end
         default: ;
      endcase
      r.fill = jfp_pkg::FILL_OUT_W'(held_count(len));
      return r;
   endfunction

   function automatic dir_row_type dir_op(input logic [jfp_pkg::ACTION_W-1:0] act,
                                          input logic [jfp_pkg::SAMPLE_W-1:0] smp,
                                          input logic be);
      dir_row_type row;
      row = '0;
      row.item = '{act, smp, be};
      return row;
   endfunction

   function automatic dir_row_type dir_chk(input logic [jfp_pkg::ACTION_W-1:0] act,
                                           input logic [jfp_pkg::SAMPLE_W-1:0] smp,
                                           input logic be, input jfp_pkg::kind_type k,
                                           input int unsigned fill, input logic ovf);
      dir_row_type row;
      row = dir_op(act, smp, be);
      row.typed = 1'b1;
      row.want = '{k, '0, jfp_pkg::FILL_OUT_W'(fill), ovf};
      return row;
   endfunction

   function automatic dir_row_type dir_cfg(input logic [jfp_pkg::LEN_REG_W-1:0] len);
      dir_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.cfg_len = len;
      return row;
   endfunction

   function automatic jitter_in_type rand_item(input logic [jfp_pkg::ACTION_W-1:0] act);
      jitter_in_type it;
      it.action = act;
      it.sample = jfp_pkg::SAMPLE_W'($urandom);
      it.burst_end = 1'($urandom);
      return it;
   endfunction

   // called just after a rising edge; returns at the edge that took the beat
   task automatic send_beat(input jitter_in_type it, input bit typed,
                            input jitter_out_type want);
      jitter_out_type got;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= it.action;
      req_ch.sample <= it.sample;
      req_ch.burst_end <= it.burst_end;
      do @(posedge clock); while (!req_ch.ready);
      got = jitter_fifo_step(it);
      jitter_out_q.push_back(typed ? want : got);
   endtask

   task automatic csr_write(input jfp_pkg::reg_idx_type idx,
                            input logic [jfp_pkg::CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= jfp_pkg::CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == jfp_pkg::REG_FIFO_LENGTH) begin
         len_csr = data[jfp_pkg::LEN_REG_W-1:0];
         head_ptr = 0;
         tail_ptr = 0;
         priming = 1'b1;
         drain_pend = 1'b0;
      end
   endtask

   // stop sending, let every owed result come back, then give the pipe time to empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (jitter_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic play_segment(input int unsigned len, inout int unsigned counted);
      int unsigned pick;
      int unsigned n;
      int unsigned cap;
      jitter_in_type it;
      pick = $urandom_range(0, 99);
      cap = (len <= 40) ? len + 2 : 24;
      n = $urandom_range(1, cap);
      if (pick < 45) begin
         for (int unsigned i = 0; i < n; i++) begin
            it = rand_item(jfp_pkg::ACT_WRITE);
            it.burst_end = (i == n - 1) ? ($urandom_range(0, 7) != 0)
                                        : ($urandom_range(0, 15) == 0);
            send_beat(it, 1'b0, '0);
            counted++;
         end
      end else if (pick < 80) begin
         for (int unsigned i = 0; i < n; i++) begin
            send_beat(rand_item(jfp_pkg::ACT_PULL), 1'b0, '0);
            counted++;
         end
      end else if (pick < 88) begin
         // flush, drain it out, then sometimes acknowledge
         send_beat(rand_item(jfp_pkg::ACT_FLUSH), 1'b0, '0);
         for (int unsigned i = 0; i < n; i++) begin
            send_beat(rand_item(jfp_pkg::ACT_PULL), 1'b0, '0);
         end
         counted += n + 1;
         if ($urandom_range(0, 1) != 0) begin
            send_beat(rand_item(jfp_pkg::ACT_DRAINED), 1'b0, '0);
            counted++;
         end
      end else if (pick < 92) begin
         send_beat(rand_item(jfp_pkg::ACT_CLEAR), 1'b0, '0);
         counted++;
      end else if (pick < 97) begin
         send_beat(rand_item(jfp_pkg::ACT_DRAINED), 1'b0, '0);
         counted++;
      end else begin
         send_beat(rand_item(jfp_pkg::ACTION_W'($urandom_range(5, 7))), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      jitter_out_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (jitter_out_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result beat: kind %0d sample %0d fill %0d ovf %0d",
                           rsp_ch.kind, rsp_ch.out_sample, rsp_ch.fill_level, rsp_ch.overflow);
               mismatch_count++;
            end else begin
               want = jitter_out_q.pop_front();
               if (want.kind !== rsp_ch.kind || want.out_sample !== rsp_ch.out_sample ||
                   want.fill !== rsp_ch.fill_level || want.overflow !== rsp_ch.overflow) begin
                  if (mismatch_count < 10)
                     $display(
                        "exp/act kind %0d/%0d sample %0d/%0d fill %0d/%0d ovf %0d/%0d",
                        want.kind, rsp_ch.kind, want.out_sample, rsp_ch.out_sample,
                        want.fill, rsp_ch.fill_level, want.overflow, rsp_ch.overflow);
                  mismatch_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int unsigned counted;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.action <= jfp_pkg::ACT_WRITE;
      req_ch.sample <= '0;
      req_ch.burst_end <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      mismatch_count = 0;
      head_ptr = 0;
      tail_ptr = 0;
      priming = 1'b1;
      drain_pend = 1'b0;
      len_csr = jfp_pkg::LEN_REG_W'(jfp_pkg::RESET_LEN);
      send_idle_pct = 12;
      recv_idle_pct = 79;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_rows = '{
         dir_chk(jfp_pkg::ACT_PULL,    16'h0000, 1'b0, jfp_pkg::KIND_UNDERRUN, 0, 1'b0),
         dir_chk(jfp_pkg::ACT_DRAINED, 16'h0000, 1'b0, jfp_pkg::KIND_NONE,     0, 1'b0),
         dir_chk(jfp_pkg::ACT_FLUSH,   16'h0000, 1'b0, jfp_pkg::KIND_FLUSH,    0, 1'b0),
         dir_chk(jfp_pkg::ACT_PULL,    16'h0000, 1'b0, jfp_pkg::KIND_FLUSH,    0, 1'b0),
         dir_chk(jfp_pkg::ACT_DRAINED, 16'h0000, 1'b0, jfp_pkg::KIND_FLUSHED,  0, 1'b0),
         dir_chk(jfp_pkg::ACT_WRITE,   16'h8000, 1'b0, jfp_pkg::KIND_NONE,     1, 1'b0),
         dir_op(jfp_pkg::ACT_PULL,     16'hffff, 1'b1),
         dir_op(jfp_pkg::ACT_WRITE,    16'h7fff, 1'b1),
         dir_op(jfp_pkg::ACT_FLUSH,    16'h0000, 1'b0),
         // flushing hands out data below the prebuffer threshold
         dir_op(jfp_pkg::ACT_PULL,     16'h0000, 1'b0),
         dir_op(jfp_pkg::ACT_PULL,     16'h0000, 1'b0),
         dir_op(jfp_pkg::ACT_PULL,     16'h0000, 1'b0),
         dir_op(jfp_pkg::ACT_CLEAR,    16'h0000, 1'b0),
         dir_op(jfp_pkg::ACT_WRITE,    16'h1234, 1'b1),
         dir_op(jfp_pkg::ACT_FLUSH,    16'h0000, 1'b0),
         dir_op(jfp_pkg::ACT_CLEAR,    16'hffff, 1'b1),
         dir_op(3'd5,                  16'h5555, 1'b0),
         dir_op(3'd7,                  16'hffff, 1'b1),
         dir_cfg(11'd2),
         dir_op(jfp_pkg::ACT_WRITE,    16'h5555, 1'b1),
         dir_chk(jfp_pkg::ACT_WRITE,   16'haaaa, 1'b0, jfp_pkg::KIND_NONE,     1, 1'b1),
         dir_op(jfp_pkg::ACT_PULL,     16'h0000, 1'b0),
         dir_chk(jfp_pkg::ACT_PULL,    16'h0000, 1'b0, jfp_pkg::KIND_UNDERRUN, 0, 1'b0)
      };

      foreach (dir_rows[r]) begin
         if (dir_rows[r].is_cfg) begin
            settle();
            csr_write(jfp_pkg::REG_FIFO_LENGTH, jfp_pkg::CSR_DATA_W'(dir_rows[r].cfg_len));
         end else begin
            send_beat(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         csr_write(jfp_pkg::REG_FIFO_LENGTH, jfp_pkg::CSR_DATA_W'(phase_len[p]));
         case (p / 3)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 79;
            end
            1: begin
               send_idle_pct = 79;
               recv_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         counted = 0;
         while (counted < ITEMS_PER_PHASE) play_segment(used_len(), counted);
      end

      settle();
      if (mismatch_count == 0 && jitter_out_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
